// File: src/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/ialu_pkg.sv
`timescale 1ns / 1ps
package ialu_pkg;

  localparam int DataWidth = 64;
  localparam int NumCells  = 64;

  localparam logic [4:0] OP_ADD    = 5'd0;
  localparam logic [4:0] OP_SUB    = 5'd1;
  localparam logic [4:0] OP_MUL    = 5'd2;
  localparam logic [4:0] OP_DIV    = 5'd3;
  localparam logic [4:0] OP_MOD    = 5'd4;
  localparam logic [4:0] OP_AND    = 5'd5;
  localparam logic [4:0] OP_OR     = 5'd6;
  localparam logic [4:0] OP_XOR    = 5'd7;
  localparam logic [4:0] OP_SHL    = 5'd8;
  localparam logic [4:0] OP_SHR    = 5'd9;
  localparam logic [4:0] OP_EQ     = 5'd10;
  localparam logic [4:0] OP_NE     = 5'd11;
  localparam logic [4:0] OP_LT     = 5'd12;
  localparam logic [4:0] OP_LE     = 5'd13;
  localparam logic [4:0] OP_GT     = 5'd14;
  localparam logic [4:0] OP_GE     = 5'd15;
  localparam logic [4:0] OP_CMP    = 5'd16;
  localparam logic [4:0] OP_NEG    = 5'd17;
  localparam logic [4:0] OP_TOBOOL = 5'd18;
  localparam logic [4:0] OP_NOT    = 5'd19;

  // Transaction as it travels down the chain.
  typedef struct packed {
    logic [4:0]           op;
    logic [DataWidth-1:0] simple;  // result of operations computed in ialu_front
    logic                 dz;
    logic                 neg_q;
    logic                 neg_r;
    logic [DataWidth-1:0] acc;     // product accumulator
    logic [DataWidth-1:0] a_sh;    // multiplicand, shifted one place per cell
    logic [DataWidth-1:0] b_sh;    // multiplier, low bit used per cell
    logic [DataWidth-1:0] rem;     // partial remainder
    logic [DataWidth-1:0] q;       // dividend in, quotient out
    logic [DataWidth-1:0] d;       // divisor magnitude
  } cell_t;

endpackage

// File: src/ialu_front.sv
`timescale 1ns / 1ps
module ialu_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [4:0]                 opcode,
  input  logic [ialu_pkg::DataWidth-1:0] operand_a,
  input  logic [ialu_pkg::DataWidth-1:0] operand_b,
  output logic                       out_valid,
  output ialu_pkg::cell_t            out_item
);
  import ialu_pkg::*;

  cell_t item_next;
  logic  lt;
  logic  gt;
  logic  eq;
  logic [DataWidth-1:0] ua;
  logic [DataWidth-1:0] ub;

  always_comb begin
    lt = $signed(operand_a) < $signed(operand_b);
    gt = $signed(operand_b) < $signed(operand_a);
    eq = operand_a == operand_b;
    ua = operand_a[DataWidth-1] ? ({DataWidth{1'b0}} - operand_a) : operand_a;
    ub = operand_b[DataWidth-1] ? ({DataWidth{1'b0}} - operand_b) : operand_b;

    item_next        = '0;
    item_next.op     = opcode;
    item_next.dz     = ((opcode == OP_DIV) || (opcode == OP_MOD)) &&
                       (operand_b == '0);
    item_next.neg_q  = operand_a[DataWidth-1] ^ operand_b[DataWidth-1];
    item_next.neg_r  = operand_a[DataWidth-1];
    item_next.acc    = '0;
    item_next.a_sh   = operand_a;
    item_next.b_sh   = operand_b;
    item_next.rem    = '0;
    item_next.q      = ua;
    item_next.d      = ub;

    unique case (opcode)
      OP_ADD:    item_next.simple = operand_a + operand_b;
      OP_SUB:    item_next.simple = operand_a - operand_b;
      OP_AND:    item_next.simple = operand_a & operand_b;
      OP_OR:     item_next.simple = operand_a | operand_b;
      OP_XOR:    item_next.simple = operand_a ^ operand_b;
      OP_SHL:    item_next.simple = operand_a << operand_b[5:0];
      OP_SHR:    item_next.simple = $signed(operand_a) >>> operand_b[5:0];
      OP_EQ:     item_next.simple = {{(DataWidth-1){1'b0}}, eq};
      OP_NE:     item_next.simple = {{(DataWidth-1){1'b0}}, !eq};
      OP_LT:     item_next.simple = {{(DataWidth-1){1'b0}}, lt};
      OP_LE:     item_next.simple = {{(DataWidth-1){1'b0}}, !gt};
      OP_GT:     item_next.simple = {{(DataWidth-1){1'b0}}, gt};
      OP_GE:     item_next.simple = {{(DataWidth-1){1'b0}}, !lt};
      OP_CMP:    item_next.simple = lt ? {DataWidth{1'b1}} :
                                    {{(DataWidth-1){1'b0}}, gt};
      OP_NEG:    item_next.simple = {DataWidth{1'b0}} - operand_a;
      OP_TOBOOL: item_next.simple = {{(DataWidth-1){1'b0}}, operand_a != '0};
      OP_NOT:    item_next.simple = {{(DataWidth-1){1'b0}}, operand_a == '0};
      default:   item_next.simple = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

// File: src/ialu_cell.sv
`timescale 1ns / 1ps
module ialu_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ialu_pkg::cell_t in_item,
  output logic            out_valid,
  output ialu_pkg::cell_t out_item
);
  import ialu_pkg::*;

  cell_t            item_next;
  logic [DataWidth:0] trial;
  logic [DataWidth:0] diff;

  always_comb begin
    item_next = in_item;
    // one multiplier bit: add the shifted multiplicand
    item_next.acc  = in_item.acc + (in_item.b_sh[0] ? in_item.a_sh : '0);
    item_next.a_sh = {in_item.a_sh[DataWidth-2:0], 1'b0};
    item_next.b_sh = {1'b0, in_item.b_sh[DataWidth-1:1]};
    // one restoring division step
    trial = {in_item.rem, in_item.q[DataWidth-1]};
    diff  = trial - {1'b0, in_item.d};
    if (!diff[DataWidth]) begin
      item_next.rem = diff[DataWidth-1:0];
      item_next.q   = {in_item.q[DataWidth-2:0], 1'b1};
    end else begin
      item_next.rem = trial[DataWidth-1:0];
      item_next.q   = {in_item.q[DataWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

// File: src/ialu_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ialu_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  ialu_pkg::cell_t                in_item,
  output logic                           en,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ialu_pkg::DataWidth-1:0] result_value,
  output logic                           divide_by_zero
);
  import ialu_pkg::*;

  logic                 skid_full;
  logic [DataWidth-1:0] skid_value;
  logic                 skid_dz;
  logic [DataWidth-1:0] res;
  logic                 p_valid;

  always_comb begin
    case (in_item.op)
      OP_MUL:  res = in_item.acc;
      OP_DIV:  res = in_item.neg_q ? ({DataWidth{1'b0}} - in_item.q) : in_item.q;
      OP_MOD:  res = in_item.neg_r ? ({DataWidth{1'b0}} - in_item.rem) : in_item.rem;
      default: res = in_item.simple;
    endcase
    if (in_item.dz) begin
      res = '0;
    end
  end

  assign en      = !skid_full;
  assign p_valid = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= p_valid;
      end
    end else if (p_valid) begin
      // output held: park the transaction
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_full) begin
        result_value   <= skid_value;
        divide_by_zero <= skid_dz;
      end else begin
        result_value   <= res;
        divide_by_zero <= in_item.dz;
      end
    end else if (p_valid) begin
      skid_value <= res;
      skid_dz    <= in_item.dz;
    end
  end

  `ASSERT_ALWAYS(a_skid_needs_out, clk, rst, !skid_full || out_valid)
  `ASSERT_ALWAYS(a_dz_zero, clk, rst, !(out_valid && divide_by_zero) || (result_value == '0))
  `ASSERT_NEXT(a_skid_drains, clk, rst, skid_full && !out_stall, !skid_full && out_valid)

endmodule

// File: src/int64_alu_with_compare.sv
`timescale 1ns / 1ps
// 64-bit integer ALU: add, sub, wrapping mul, truncating signed div and mod,
// bitwise ops, shifts, comparisons and three-way compare, neg, to-bool, not.
// Takes one transaction per cycle while in_stall is low; each accepted
// transaction passes through one decode stage, a chain of 64 cells that each
// retire one multiplier bit and one quotient bit, and one output stage. Results
// come out in order. A two-entry output buffer lets the block keep accepting
// while a result waits; stall on the input rises only when both are full.
module int64_alu_with_compare (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [4:0]                     opcode,
  input  logic [ialu_pkg::DataWidth-1:0] operand_a,
  input  logic [ialu_pkg::DataWidth-1:0] operand_b,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ialu_pkg::DataWidth-1:0] result_value,
  output logic                           divide_by_zero
);
  import ialu_pkg::*;

  logic  en;
  logic  v   [NumCells+1];
  cell_t itm [NumCells+1];

  assign in_stall = !en;

  ialu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (v[0]),
    .out_item  (itm[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    ialu_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v[i]),
      .in_item   (itm[i]),
      .out_valid (v[i+1]),
      .out_item  (itm[i+1])
    );
  end

  ialu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (v[NumCells]),
    .in_item        (itm[NumCells]),
    .en             (en),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_value   (result_value),
    .divide_by_zero (divide_by_zero)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ialu_pkg::*;

  localparam int Latency = 66;

  typedef struct {
    logic [4:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_op_t;

  typedef struct {
    logic [63:0] value;
    logic        dz;
  } alu_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  opcode = '0;
  logic [63:0] operand_a = '0;
  logic [63:0] operand_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result_value;
  logic        divide_by_zero;

  alu_op_t  pending_ops[$];
  alu_res_t expected_results[$];
  int       error_count = 0;
  bit       stimulus_done = 1'b0;
  bit       drain_request = 1'b0;
  int       long_hold = 0;

  int64_alu_with_compare i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .divide_by_zero(divide_by_zero)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic alu_res_t compute_alu(alu_op_t t);
    alu_res_t    r;
    logic [63:0] ma, mb;
    logic        lt, gt;
    r.value = '0;
    r.dz = 1'b0;
    lt = $signed(t.a) < $signed(t.b);
    gt = $signed(t.b) < $signed(t.a);
    ma = t.a[63] ? -t.a : t.a;
    mb = t.b[63] ? -t.b : t.b;
    case (t.op)
      OP_ADD: r.value = t.a + t.b;
      OP_SUB: r.value = t.a - t.b;
      OP_MUL: r.value = t.a * t.b;
      OP_DIV, OP_MOD: begin
        if (t.b == 0) begin
          r.dz = 1'b1;
        end else if (t.op == OP_DIV) begin
          r.value = ma / mb;
          if (t.a[63] ^ t.b[63]) r.value = -r.value;
        end else begin
          r.value = ma % mb;
          if (t.a[63]) r.value = -r.value;
        end
      end
      OP_AND: r.value = t.a & t.b;
      OP_OR:  r.value = t.a | t.b;
      OP_XOR: r.value = t.a ^ t.b;
      OP_SHL: r.value = t.a << t.b[5:0];
      OP_SHR: r.value = $signed(t.a) >>> t.b[5:0];
      OP_EQ:  r.value = 64'(t.a == t.b);
      OP_NE:  r.value = 64'(t.a != t.b);
      OP_LT:  r.value = 64'(lt);
      OP_LE:  r.value = 64'(!gt);
      OP_GT:  r.value = 64'(gt);
      OP_GE:  r.value = 64'(!lt);
      OP_CMP: r.value = lt ? '1 : (gt ? 64'd1 : 64'd0);
      OP_NEG: r.value = -t.a;
      OP_TOBOOL: r.value = 64'(t.a != 0);
      OP_NOT: r.value = 64'(t.a == 0);
      default: r.value = '0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7fff_ffff_ffff_ffff;
      2: v = '1;
      3: v = '0;
      4: v = 64'($signed($urandom_range(0, 40)) - 20);
      5: v = {{32{v[31]}}, v[31:0]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_op(logic [4:0] op, logic [63:0] a, logic [63:0] b);
    alu_op_t t;
    t.op = op;
    t.a = a;
    t.b = b;
    pending_ops.push_back(t);
  endtask

  // Driver: hold the transaction until accepted, then draw a gap.
  int gap = 0;
  bit pause_done = 1'b0;
  always @(posedge clk) begin
    alu_op_t t;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(compute_alu('{opcode, operand_a, operand_b}));
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0;
      end
      if (in_valid && in_stall) begin
      end else if (gap > 0) begin
        gap = gap - 1;
        in_valid <= 1'b0;
      end else if (drain_request && !pause_done && expected_results.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        if (drain_request) pause_done = 1'b1;
        t = pending_ops.pop_front();
        in_valid <= 1'b1;
        opcode <= t.op;
        operand_a <= t.a;
        operand_b <= t.b;
      end else begin
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  int stall_left = 0;
  always @(posedge clk) begin
    alu_res_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result value=%h", result_value);
          error_count++;
        end else begin
          e = expected_results.pop_front();
          if (result_value !== e.value) begin
            $error("result_value expected %h actual %h", e.value, result_value);
            error_count++;
          end
          if (divide_by_zero !== e.dz) begin
            $error("divide_by_zero expected %b actual %b", e.dz, divide_by_zero);
            error_count++;
          end
        end
      end
      // long hold once, when more than 20 results are outstanding
      if (long_hold == 0 && expected_results.size() > 20) begin
        long_hold = 1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_stall <= stall_left != 0;
        if (stall_left > 0) stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [63:0] mn, mx;
    alu_op_t     t;
    mn = 64'h8000_0000_0000_0000;
    mx = 64'h7fff_ffff_ffff_ffff;
    for (int op = 0; op < 32; op++) begin
      add_op(5'(op), mx, 64'd3);
    end
    add_op(OP_DIV, mn, '1);
    add_op(OP_MOD, mn, '1);
    add_op(OP_DIV, 64'd7, '0);
    add_op(OP_MOD, -64'd7, '0);
    add_op(OP_DIV, -64'd7, 64'd2);
    add_op(OP_MOD, -64'd7, 64'd2);
    add_op(OP_SHL, '1, 64'hffff_ffff_ffff_ff7f);
    add_op(OP_SHR, mn, 64'd63);
    add_op(OP_CMP, mn, mx);
    add_op(OP_MUL, mx, mx);
    for (int i = 0; i < 300; i++) begin
      t.op = $urandom_range(0, 6) == 0 ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 19));
      t.a = rand_operand();
      t.b = ($urandom_range(0, 3) == 0) ? t.a : rand_operand();
      add_op(t.op, t.a, t.b);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending_ops.size() == 0);
    // Second half after a full drain.
    for (int i = 0; i < 300; i++) begin
      t.op = 5'($urandom_range(0, 31));
      t.a = rand_operand();
      t.b = rand_operand();
      add_op(t.op, t.a, t.b);
    end
    drain_request = 1'b1;
    wait (stimulus_done && !in_valid);
    wait (expected_results.size() == 0);
    repeat (Latency + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/ialu_pkg.sv
src/ialu_front.sv
src/ialu_cell.sv
src/ialu_back.sv
src/int64_alu_with_compare.sv
verif/testbench.sv
